FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sprite tile expander.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication that is tested at every clock edge outside of reset.
`define STE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

FILE: rtl/ste_pkg.sv
// Shared types, constants and helpers for the sprite tile expander.
// Used by ste_ctrl, ste_dp and sprite_tile_expander; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ste_pkg;

	// Controller states.
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} ste_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
	} ste_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
	} ste_sts_t;

	// Position offsets, all taken modulo 2^11.
	localparam logic [10:0] X_BIAS      = 11'd256;
	localparam logic [10:0] Y_BASE      = 11'd512;
	localparam logic [10:0] X_FLIP_BASE = 11'd768;

	// Turns a log2 size code into the largest tile index along that axis.
	function automatic logic [2:0] size_mask(input logic [1:0] size_log);
		logic [2:0] mask;
		unique case (size_log)
			2'd0: mask = 3'd0;
			2'd1: mask = 3'd1;
			2'd2: mask = 3'd3;
			default: mask = 3'd7;
		endcase
		return mask;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/ste_ctrl.sv
// Controller state machine of the sprite tile expander.
// Depends on ste_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module ste_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire ste_pkg::ste_sts_t sts,
	output ste_pkg::ste_cmd_t    cmd,
	output logic                 busy
);

	ste_pkg::ste_state_t state_q;
	ste_pkg::ste_state_t state_n;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ste_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state: a request starts a run, the final tile ends it.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ste_pkg::ST_IDLE: begin
				if (start) begin
					state_n = ste_pkg::ST_RUN;
				end
			end
			ste_pkg::ST_RUN: begin
				if (sts.last) begin
					state_n = ste_pkg::ST_IDLE;
				end
			end
			default: state_n = ste_pkg::ST_IDLE;
		endcase
	end

	// Outputs: load on an accepted request, one tile step per cycle while running.
	always_comb begin
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		busy     = 1'b0;
		unique case (state_q)
			ste_pkg::ST_IDLE: begin
				cmd.load = start;
			end
			ste_pkg::ST_RUN: begin
				cmd.step = 1'b1;
				busy     = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/ste_dp.sv
// Datapath of the sprite tile expander: sprite registers, tile counters and result registers.
// Depends on ste_pkg for constants, the size mask helper and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module ste_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wen,
	input  wire logic              cfg_wdata,
	input  wire ste_pkg::ste_cmd_t cmd,
	output ste_pkg::ste_sts_t      sts,
	input  wire logic [8:0]        raw_y,
	input  wire logic [15:0]       base_code,
	input  wire logic [3:0]        palette_index,
	input  wire logic              mirror_x,
	input  wire logic              mirror_y,
	input  wire logic [1:0]        width_log,
	input  wire logic [1:0]        height_log,
	input  wire logic [9:0]        raw_x,
	input  wire logic              final_sprite,
	output logic                   tile_strobe,
	output logic [15:0]            tile_number,
	output logic [3:0]             tile_palette,
	output logic                   draw_flip_x,
	output logic                   draw_flip_y,
	output logic signed [10:0]     screen_x,
	output logic signed [10:0]     screen_y,
	output logic                   last_tile,
	output logic                   list_done
);

	logic        screen_flip_q;
	logic [15:0] base_q;
	logic [3:0]  pal_q;
	logic        fx_q;
	logic        fy_q;
	logic [2:0]  wmask_q;
	logic [2:0]  hmask_q;
	logic [10:0] sx_q;
	logic [10:0] sy_q;
	logic        fin_q;
	logic [2:0]  col_q;
	logic [2:0]  row_q;

	logic [2:0]  wmask_n;
	logic [2:0]  hmask_n;
	logic [10:0] span_w;
	logic [10:0] span_h;
	logic [10:0] sx_n;
	logic [10:0] sy_n;
	logic [2:0]  col_eff;
	logic [2:0]  row_eff;
	logic        at_last;

	logic        strobe_q;
	logic [15:0] number_q;
	logic [3:0]  palette_q;
	logic        flip_x_q;
	logic        flip_y_q;
	logic [10:0] pos_x_q;
	logic [10:0] pos_y_q;
	logic        last_q;
	logic        done_q;

	// Screen flip register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_flip_q <= 1'b0;
		end else if (cfg_wen) begin
			screen_flip_q <= cfg_wdata;
		end
	end

	// Sprite origin from the raw position; the sizes in pixels are 16 times the tile counts.
	assign wmask_n = ste_pkg::size_mask(width_log);
	assign hmask_n = ste_pkg::size_mask(height_log);
	assign span_w  = {3'b000, {1'b0, wmask_n} + 4'd1, 4'b0000};
	assign span_h  = {3'b000, {1'b0, hmask_n} + 4'd1, 4'b0000};

	always_comb begin
		if (screen_flip_q) begin
			sx_n = ste_pkg::X_FLIP_BASE - span_w - {1'b0, raw_x};
			sy_n = {2'b00, raw_y};
		end else begin
			sx_n = {1'b0, raw_x} - ste_pkg::X_BIAS;
			sy_n = ste_pkg::Y_BASE - {2'b00, raw_y} - span_h;
		end
	end

	// Sprite registers, captured when a request is accepted.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q  <= base_code;
			pal_q   <= palette_index;
			fx_q    <= mirror_x ^ screen_flip_q;
			fy_q    <= mirror_y ^ screen_flip_q;
			wmask_q <= wmask_n;
			hmask_q <= hmask_n;
			sx_q    <= sx_n;
			sy_q    <= sy_n;
			fin_q   <= final_sprite;
		end
	end

	// Tile counters: rows inner, columns outer.
	assign at_last = (col_q == wmask_q) && (row_q == hmask_q);
	assign sts.last = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 3'd0;
			row_q <= 3'd0;
		end else if (cmd.load) begin
			col_q <= 3'd0;
			row_q <= 3'd0;
		end else if (cmd.step) begin
			if (row_q == hmask_q) begin
				row_q <= 3'd0;
				col_q <= col_q + 3'd1;
			end else begin
				row_q <= row_q + 3'd1;
			end
		end
	end

	// Under a flip the index counts from the far side, which is the index XOR the mask.
	assign col_eff = fx_q ? (col_q ^ wmask_q) : col_q;
	assign row_eff = fy_q ? (row_q ^ hmask_q) : row_q;

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.step;
		end
	end

	// Result registers for the current tile.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			number_q  <= base_q + {10'd0, col_eff, 3'b000} + {13'd0, row_eff};
			palette_q <= pal_q;
			flip_x_q  <= fx_q;
			flip_y_q  <= fy_q;
			pos_x_q   <= sx_q + {4'd0, col_q, 4'b0000};
			pos_y_q   <= sy_q + {4'd0, row_q, 4'b0000};
			last_q    <= at_last;
			done_q    <= at_last & fin_q;
		end
	end

	assign tile_strobe  = strobe_q;
	assign tile_number  = number_q;
	assign tile_palette = palette_q;
	assign draw_flip_x  = flip_x_q;
	assign draw_flip_y  = flip_y_q;
	assign screen_x     = $signed(pos_x_q);
	assign screen_y     = $signed(pos_y_q);
	assign last_tile    = last_q;
	assign list_done    = done_q;

endmodule

`default_nettype wire

FILE: rtl/sprite_tile_expander.sv
// Sprite tile expander: a sprite entry in, one draw request per 16x16 tile out.
// Top level; depends on ste_pkg, ste_ctrl, ste_dp and assert_macros.svh.
//
// A sprite entry is taken at a clock edge where start is high and busy is low, and the sprite
// registers load at that edge. busy then stays high while the block steps through the w*h tiles
// (1 to 64) of a w by h sprite, one tile per step, and a new entry can be accepted
// on the cycle the final tile is shown. The pace is set by the tile counter, which steps once a
// cycle, rows inner and columns outer. Each tile appears for exactly one cycle with tile_strobe
// high; the receiver cannot stall, so it must take every tile as it comes. screen_flip is taken
// from cfg_wdata when cfg_wen is high and should only change while busy is low.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sprite_tile_expander (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wen,
	input  wire logic              cfg_wdata,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [8:0]        raw_y,
	input  wire logic [15:0]       base_code,
	input  wire logic [3:0]        palette_index,
	input  wire logic              mirror_x,
	input  wire logic              mirror_y,
	input  wire logic [1:0]        width_log,
	input  wire logic [1:0]        height_log,
	input  wire logic [9:0]        raw_x,
	input  wire logic              final_sprite,
	output logic                   tile_strobe,
	output logic [15:0]            tile_number,
	output logic [3:0]             tile_palette,
	output logic                   draw_flip_x,
	output logic                   draw_flip_y,
	output logic signed [10:0]     screen_x,
	output logic signed [10:0]     screen_y,
	output logic                   last_tile,
	output logic                   list_done
);

	ste_pkg::ste_cmd_t cmd;
	ste_pkg::ste_sts_t sts;

	// Controller.
	ste_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath.
	ste_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.sts           (sts),
		.raw_y         (raw_y),
		.base_code     (base_code),
		.palette_index (palette_index),
		.mirror_x      (mirror_x),
		.mirror_y      (mirror_y),
		.width_log     (width_log),
		.height_log    (height_log),
		.raw_x         (raw_x),
		.final_sprite  (final_sprite),
		.tile_strobe   (tile_strobe),
		.tile_number   (tile_number),
		.tile_palette  (tile_palette),
		.draw_flip_x   (draw_flip_x),
		.draw_flip_y   (draw_flip_y),
		.screen_x      (screen_x),
		.screen_y      (screen_y),
		.last_tile     (last_tile),
		.list_done     (list_done)
	);

	// An accepted request occupies the block on the following cycle.
	`STE_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
	// A tile is only shown after the block has been busy.
	`STE_ASSERT(a_strobe_after_busy, tile_strobe |-> $past(busy), "tile shown without work")
	// Finishing a sprite coincides with showing its final tile.
	`STE_ASSERT(a_end_last_tile, $fell(busy) |-> (tile_strobe && last_tile),
		"busy dropped without the final tile")
	// The end of the list is only flagged on a sprite's final tile.
	`STE_ASSERT(a_done_is_last, (tile_strobe && list_done) |-> last_tile,
		"list end flagged on an inner tile")

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for sprite_tile_expander: sends sprite entries, predicts every
// tile draw request and compares each strobed result with the oldest prediction.
// Depends only on the sprite_tile_expander RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS  = 65;

	// One sprite entry as it goes into the block.
	typedef struct {
		logic [8:0]  raw_y;
		logic [15:0] base_code;
		logic [3:0]  palette_index;
		logic        mirror_x;
		logic        mirror_y;
		logic [1:0]  width_log;
		logic [1:0]  height_log;
		logic [9:0]  raw_x;
		logic        final_sprite;
	} sprite_entry_t;

	// One tile draw request as it comes out of the block.
	typedef struct {
		logic [15:0]        tile_number;
		logic [3:0]         tile_palette;
		logic               draw_flip_x;
		logic               draw_flip_y;
		logic signed [10:0] screen_x;
		logic signed [10:0] screen_y;
		logic               last_tile;
		logic               list_done;
	} tile_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic cfg_wdata = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [8:0] raw_y = '0;
	logic [15:0] base_code = '0;
	logic [3:0] palette_index = '0;
	logic mirror_x = 1'b0;
	logic mirror_y = 1'b0;
	logic [1:0] width_log = '0;
	logic [1:0] height_log = '0;
	logic [9:0] raw_x = '0;
	logic final_sprite = 1'b0;
	logic tile_strobe;
	logic [15:0] tile_number;
	logic [3:0] tile_palette;
	logic draw_flip_x;
	logic draw_flip_y;
	logic signed [10:0] screen_x;
	logic signed [10:0] screen_y;
	logic last_tile;
	logic list_done;

	// Predicted tiles not yet seen, oldest first.
	tile_cmd_t expected_tiles[$];
	// Copy of the screen flip register.
	bit flip_screen_cfg = 1'b0;
	bit failed = 1'b0;
	bit no_gaps = 1'b0;
	int stall_cycles = 0;

	sprite_tile_expander dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.raw_y(raw_y),
		.base_code(base_code),
		.palette_index(palette_index),
		.mirror_x(mirror_x),
		.mirror_y(mirror_y),
		.width_log(width_log),
		.height_log(height_log),
		.raw_x(raw_x),
		.final_sprite(final_sprite),
		.tile_strobe(tile_strobe),
		.tile_number(tile_number),
		.tile_palette(tile_palette),
		.draw_flip_x(draw_flip_x),
		.draw_flip_y(draw_flip_y),
		.screen_x(screen_x),
		.screen_y(screen_y),
		.last_tile(last_tile),
		.list_done(list_done)
	);

	// Free-running clock.
	initial begin
		forever #10 clk = ~clk;
	end

	// Expands one sprite into its tile requests, columns outer and rows inner.
	function automatic void expand_sprite(input sprite_entry_t s);
		int w;
		int h;
		int sx;
		int sy;
		bit fx;
		bit fy;
		tile_cmd_t t;
		w = 1 << s.width_log;
		h = 1 << s.height_log;
		sx = int'(s.raw_x) - 256;
		sy = 512 - int'(s.raw_y) - 16 * h;
		fx = s.mirror_x;
		fy = s.mirror_y;
		// A flipped screen mirrors the origin and inverts both sprite flips.
		if (flip_screen_cfg) begin
			sx = 512 - 16 * w - sx;
			sy = 512 - 16 * h - sy;
			fx = !fx;
			fy = !fy;
		end
		for (int col = 0; col < w; col++) begin
			for (int row = 0; row < h; row++) begin
				t.tile_number = 16'(int'(s.base_code) + 8 * (fx ? w - 1 - col : col)
					+ (fy ? h - 1 - row : row));
				t.tile_palette = s.palette_index;
				t.draw_flip_x = fx;
				t.draw_flip_y = fy;
				t.screen_x = 11'(sx + 16 * col);
				t.screen_y = 11'(sy + 16 * row);
				t.last_tile = (col == w - 1) && (row == h - 1);
				t.list_done = t.last_tile && s.final_sprite;
				expected_tiles.push_back(t);
			end
		end
	endfunction

	function automatic sprite_entry_t make_sprite(input logic [8:0] ry, input logic [15:0] code,
			input logic [3:0] pal, input logic mx, input logic my, input logic [1:0] wl,
			input logic [1:0] hl, input logic [9:0] rx, input logic fin);
		sprite_entry_t s;
		s.raw_y = ry;
		s.base_code = code;
		s.palette_index = pal;
		s.mirror_x = mx;
		s.mirror_y = my;
		s.width_log = wl;
		s.height_log = hl;
		s.raw_x = rx;
		s.final_sprite = fin;
		return s;
	endfunction

	// Random entry; one in eight sits near the top of the tile code range to force wrapping.
	function automatic sprite_entry_t random_sprite();
		sprite_entry_t s;
		s = make_sprite(9'($urandom), 16'($urandom), 4'($urandom), 1'($urandom), 1'($urandom),
			2'($urandom), 2'($urandom), 10'($urandom), 1'($urandom));
		if ($urandom_range(7) == 0)
			s.base_code = 16'hFFC0 + 16'($urandom_range(63));
		return s;
	endfunction

	// Presents one sprite request and returns at the edge that accepts it.
	task automatic send_sprite(input sprite_entry_t s);
		start <= 1'b1;
		raw_y <= s.raw_y;
		base_code <= s.base_code;
		palette_index <= s.palette_index;
		mirror_x <= s.mirror_x;
		mirror_y <= s.mirror_y;
		width_log <= s.width_log;
		height_log <= s.height_log;
		raw_x <= s.raw_x;
		final_sprite <= s.final_sprite;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		expand_sprite(s);
	endtask

	// Random gap between requests, skipped during the back-to-back stretch.
	task automatic maybe_pause();
		if (!no_gaps && $urandom_range(99) < 32) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Holds off new requests until every predicted tile has come out.
	task automatic wait_drained();
		start <= 1'b0;
		while (expected_tiles.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// The register is only written with the block idle.
	task automatic set_screen_flip(input bit value);
		wait_drained();
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		flip_screen_cfg = value;
	endtask

	// Every size pair, with flips, position extremes and tile code wrap.
	task automatic test_sprite_sizes();
		logic [3:0] i;
		set_screen_flip(1'b0);
		for (int n = 0; n < 16; n++) begin
			i = 4'(n);
			send_sprite(make_sprite(i[0] ? 9'd511 : 9'd0, 16'hFFFF - i, i, i[0] ^ i[3],
				i[1] ^ i[2], i[3:2], i[1:0], i[1] ? 10'd1023 : 10'd0, i[3]));
		end
	endtask

	// Flipped screen with the extremes of position and size.
	task automatic test_screen_flip();
		set_screen_flip(1'b1);
		send_sprite(make_sprite(9'd511, 16'hFFC0, 4'd15, 1'b0, 1'b0, 2'd3, 2'd3, 10'd1023, 1'b1));
		send_sprite(make_sprite(9'd0, 16'h0000, 4'd0, 1'b1, 1'b1, 2'd0, 2'd0, 10'd0, 1'b0));
		maybe_pause();
		send_sprite(make_sprite(9'd256, 16'h1234, 4'd5, 1'b1, 1'b0, 2'd2, 2'd1, 10'd256, 1'b1));
		send_sprite(make_sprite(9'd100, 16'hFFFE, 4'd10, 1'b0, 1'b1, 2'd1, 2'd3, 10'd700, 1'b0));
	endtask

	// Random sprites in phases, each phase with its own screen flip setting.
	task automatic test_random_sprites();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_screen_flip(p < 2 ? p[0] : 1'($urandom_range(1)));
			no_gaps = (p == 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 3 && k == PHASE_ITEMS / 2)
					wait_drained();
				send_sprite(random_sprite());
				maybe_pause();
			end
		end
		no_gaps = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [15:0] expv,
			input logic [15:0] actv);
		if (actv !== expv) begin
			$display("%0t: %s expected %h, actual %h", $time, name, expv, actv);
			failed = 1'b1;
		end
	endtask

	// Compares every strobed tile with the oldest prediction.
	always @(posedge clk) begin : tile_checker
		tile_cmd_t want;
		if (arst_n && tile_strobe === 1'b1) begin
			if (expected_tiles.size() == 0) begin
				$display("%0t: tile %h with no request pending", $time, tile_number);
				failed = 1'b1;
			end else begin
				want = expected_tiles.pop_front();
				check_field("tile_number", want.tile_number, tile_number);
				check_field("tile_palette", 16'(want.tile_palette), 16'(tile_palette));
				check_field("draw_flip_x", 16'(want.draw_flip_x), 16'(draw_flip_x));
				check_field("draw_flip_y", 16'(want.draw_flip_y), 16'(draw_flip_y));
				check_field("screen_x", 16'(want.screen_x), 16'(screen_x));
				check_field("screen_y", 16'(want.screen_y), 16'(screen_y));
				check_field("last_tile", 16'(want.last_tile), 16'(last_tile));
				check_field("list_done", 16'(want.list_done), 16'(list_done));
			end
		end
	end

	// Ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || tile_strobe === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sprite_sizes();
		test_screen_flip();
		test_random_sprites();
		wait_drained();
		repeat (70) @(posedge clk);
		if (expected_tiles.size() != 0) begin
			$display("%0t: %0d predicted tiles never came out", $time, expected_tiles.size());
			failed = 1'b1;
		end
		if (!failed)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
